[src/tms_pkg.sv]
// Package for the tape machine step block: sizes, opcodes and the result record.
// No dependencies; used by the top level, the result queue, the checker and the testbench.
`default_nettype none

package tms_pkg;

    localparam int TAPE_CELLS    = 65536;
    localparam int TAPE_AW       = $clog2(TAPE_CELLS);
    localparam int PROGRAM_DEPTH = 1048576;
    localparam int ADDR_W        = 21;
    localparam int TARGET_W      = 20;
    localparam int OP_W          = 3;
    localparam int BYTE_W        = 8;

    // result queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = OUT_AW + 1;

    localparam logic [OP_W-1:0] OP_RIGHT = 3'd0;
    localparam logic [OP_W-1:0] OP_LEFT  = 3'd1;
    localparam logic [OP_W-1:0] OP_INC   = 3'd2;
    localparam logic [OP_W-1:0] OP_DEC   = 3'd3;
    localparam logic [OP_W-1:0] OP_OUT   = 3'd4;
    localparam logic [OP_W-1:0] OP_IN    = 3'd5;
    localparam logic [OP_W-1:0] OP_OPEN  = 3'd6;
    localparam logic [OP_W-1:0] OP_CLOSE = 3'd7;

    typedef struct packed {
        logic [ADDR_W-1:0] next_address;
        logic              out_valid;
        logic [BYTE_W-1:0] out_byte;
        logic              halted;
    } t_result;

    typedef struct packed {
        logic              push;
        logic              pop;
    } t_fifo_ctl;

endpackage

`default_nettype wire

[src/tape_machine_step.sv]
// Top level of the tape machine step block: one instruction per input transfer.
// Depends on tms_pkg, tms_ram and tms_out_fifo.
//
// Each input transfer executes one instruction of the eight-opcode byte-tape
// machine and yields exactly one result transfer. The tape lives in a
// single-port-per-direction RAM: the cell under the data pointer is read in
// the cycle the instruction is taken, then modified and written back the next
// cycle, with the last write forwarded so a new instruction can be taken every
// cycle while o_stall is low (one instruction per clock sustained; the result
// enters a four-entry result queue in the cycle after its input transfer and
// can transfer out the cycle after that). After reset the block clears the
// tape one cell per clock, holding o_stall high; program_length may be written
// during that time. Instructions arriving once the instruction address reaches
// program_length, capped at PROGRAM_DEPTH, leave all state untouched and report
// halted. Write program_length only while no transfer is in flight.
`default_nettype none

module tape_machine_step
    import tms_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration
    input  wire logic                i_cfg_valid,
    input  wire logic [ADDR_W-1:0]   i_cfg_data,
    output logic                     o_cfg_ready,
    // instruction channel
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [OP_W-1:0]     i_opcode,
    input  wire logic [TARGET_W-1:0] i_jump_target,
    input  wire logic [BYTE_W-1:0]   i_in_byte,
    // result channel
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [ADDR_W-1:0]        o_next_address,
    output logic                     o_out_valid,
    output logic [BYTE_W-1:0]        o_out_byte,
    output logic                     o_halted
);

    // configuration
    logic [ADDR_W-1:0]   r_prog_len;
    logic [ADDR_W-1:0]   len_eff;

    // tape clear after reset
    logic                r_clr_busy;
    logic [TAPE_AW-1:0]  r_clr_addr;

    // architectural state
    logic [ADDR_W-1:0]   r_ia;
    logic [TAPE_AW-1:0]  r_dp;       // committed pointer
    logic [TAPE_AW-1:0]  r_dp_spec;  // pointer as of the last accepted instruction

    // execute stage
    logic                r_s2_vld;
    logic [OP_W-1:0]     r_s2_op;
    logic [TARGET_W-1:0] r_s2_tgt;
    logic [BYTE_W-1:0]   r_s2_byte;
    logic [TAPE_AW-1:0]  r_s2_dp;

    // last tape write, forwarded into the read path
    logic                r_fwd_vld;
    logic [TAPE_AW-1:0]  r_fwd_addr;
    logic [BYTE_W-1:0]   r_fwd_data;

    logic                accept;
    logic [OUT_CW-1:0]   fifo_count;
    logic [OUT_CW-1:0]   occupancy;
    t_fifo_ctl           fifo_ctl;
    t_result             s2_res;
    t_result             head;

    logic [BYTE_W-1:0]   ram_rdata;
    logic                ram_we;
    logic [TAPE_AW-1:0]  ram_waddr;
    logic [BYTE_W-1:0]   ram_wdata;

    logic                halt_in;
    logic [BYTE_W-1:0]   cur_byte;
    logic [BYTE_W-1:0]   cell_new;
    logic                cell_we;
    logic [ADDR_W-1:0]   next_addr;
    logic [TAPE_AW-1:0]  dp_new;
    logic [TAPE_AW-1:0]  dp_spec_new;

    assign o_cfg_ready = 1'b1;

    assign len_eff = (r_prog_len > ADDR_W'(PROGRAM_DEPTH)) ? ADDR_W'(PROGRAM_DEPTH)
                                                           : r_prog_len;

    // room is reserved for everything already in flight, so stall never waits on i_stall
    assign occupancy = fifo_count + OUT_CW'(r_s2_vld);
    assign o_stall   = r_clr_busy || (occupancy >= OUT_CW'(OUT_DEPTH));
    assign accept    = i_valid && !o_stall;

    always_comb begin
        dp_spec_new = r_dp_spec;
        if (i_opcode == OP_RIGHT) begin
            dp_spec_new = r_dp_spec + TAPE_AW'(1);
        end else if (i_opcode == OP_LEFT) begin
            dp_spec_new = r_dp_spec - TAPE_AW'(1);
        end
    end

    // execute
    assign halt_in  = r_ia >= len_eff;
    assign cur_byte = (r_fwd_vld && (r_fwd_addr == r_s2_dp)) ? r_fwd_data : ram_rdata;

    always_comb begin
        next_addr = r_ia + ADDR_W'(1);
        dp_new    = r_s2_dp;
        cell_new  = cur_byte;
        cell_we   = 1'b0;
        unique case (r_s2_op)
            OP_RIGHT: begin
                dp_new = r_s2_dp + TAPE_AW'(1);
            end
            OP_LEFT: begin
                dp_new = r_s2_dp - TAPE_AW'(1);
            end
            OP_INC: begin
                cell_new = cur_byte + BYTE_W'(1);
                cell_we  = 1'b1;
            end
            OP_DEC: begin
                cell_new = cur_byte - BYTE_W'(1);
                cell_we  = 1'b1;
            end
            OP_OUT: begin
            end
            OP_IN: begin
                cell_new = r_s2_byte;
                cell_we  = 1'b1;
            end
            OP_OPEN: begin
                if (cur_byte == '0) begin
                    next_addr = {1'b0, r_s2_tgt} + ADDR_W'(1);
                end
            end
            OP_CLOSE: begin
                if (cur_byte != '0) begin
                    next_addr = {1'b0, r_s2_tgt} + ADDR_W'(1);
                end
            end
        endcase
    end

    always_comb begin
        if (halt_in) begin
            s2_res.next_address = r_ia;
            s2_res.out_valid    = 1'b0;
            s2_res.out_byte     = '0;
            s2_res.halted       = 1'b1;
        end else begin
            s2_res.next_address = next_addr;
            s2_res.out_valid    = (r_s2_op == OP_OUT);
            s2_res.out_byte     = (r_s2_op == OP_OUT) ? cur_byte : '0;
            s2_res.halted       = next_addr >= len_eff;
        end
    end

    always_comb begin
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = r_s2_vld && !halt_in && cell_we;
            ram_waddr = r_s2_dp;
            ram_wdata = cell_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_len <= '0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_ia       <= '0;
            r_dp       <= '0;
            r_dp_spec  <= '0;
            r_s2_vld   <= 1'b0;
            r_fwd_vld  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_prog_len <= i_cfg_data;
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + TAPE_AW'(1);
                if (r_clr_addr == {TAPE_AW{1'b1}}) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_s2_vld <= accept;
            // a halted instruction means every later one in this burst is halted too,
            // so the speculative pointer falls back to the committed one
            if (r_s2_vld && halt_in) begin
                r_dp_spec <= r_dp;
            end else if (accept) begin
                r_dp_spec <= dp_spec_new;
            end
            if (r_s2_vld && !halt_in) begin
                r_ia <= next_addr;
                r_dp <= dp_new;
            end
            if (!r_clr_busy && ram_we) begin
                r_fwd_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_op   <= i_opcode;
            r_s2_tgt  <= i_jump_target;
            r_s2_byte <= i_in_byte;
            r_s2_dp   <= r_dp_spec;
        end
        if (!r_clr_busy && ram_we) begin
            r_fwd_addr <= ram_waddr;
            r_fwd_data <= ram_wdata;
        end
    end

    tms_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TAPE_CELLS)
    ) u_tape (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (r_dp_spec),
        .o_rdata (ram_rdata)
    );

    assign fifo_ctl.push = r_s2_vld;
    assign fifo_ctl.pop  = o_valid && !i_stall;

    tms_out_fifo u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fifo_ctl),
        .i_data  (s2_res),
        .o_head  (head),
        .o_count (fifo_count)
    );

    assign o_valid        = (fifo_count != '0);
    assign o_next_address = head.next_address;
    assign o_out_valid    = head.out_valid;
    assign o_out_byte     = head.out_byte;
    assign o_halted       = head.halted;

    a_no_exec_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_s2_vld)
        else $error("instruction executed during tape clear");

    a_halt_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && halt_in) |=> (r_ia == $past(r_ia) && r_dp == $past(r_dp)))
        else $error("halted instruction changed state");

    a_room_for_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> (fifo_count < OUT_CW'(OUT_DEPTH) || fifo_ctl.pop))
        else $error("execute stage has no room in result queue");

    a_byte_only_on_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && s2_res.out_byte != '0) |-> (r_s2_op == OP_OUT))
        else $error("output byte produced by a non-output opcode");

endmodule

`default_nettype wire

[src/tms_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module tms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[src/tms_out_fifo.sv]
// Small result queue between the execute stage and the output channel.
// Depends on tms_pkg.
`default_nettype none

module tms_out_fifo
    import tms_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_fifo_ctl         i_ctl,
    input  wire t_result           i_data,
    output t_result                o_head,
    output logic [OUT_CW-1:0]      o_count
);

    t_result            r_buf [OUT_DEPTH];
    logic [OUT_AW-1:0]  r_wr_ptr;
    logic [OUT_AW-1:0]  r_rd_ptr;
    logic [OUT_CW-1:0]  r_count;
    logic [OUT_CW-1:0]  n_count;

    always_comb begin
        n_count = r_count;
        if (i_ctl.push && !i_ctl.pop) begin
            n_count = r_count + OUT_CW'(1);
        end else if (!i_ctl.push && i_ctl.pop) begin
            n_count = r_count - OUT_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_ctl.push) begin
                r_wr_ptr <= r_wr_ptr + OUT_AW'(1);
            end
            if (i_ctl.pop) begin
                r_rd_ptr <= r_rd_ptr + OUT_AW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    assign o_head  = r_buf[r_rd_ptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == OUT_CW'(OUT_DEPTH)) |-> (!i_ctl.push || i_ctl.pop))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> (r_count != '0))
        else $error("result queue underflow");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.push && !i_ctl.pop) |=> (r_count == $past(r_count) + OUT_CW'(1)))
        else $error("result queue count did not advance on push");

endmodule

`default_nettype wire

[verif/tms_checker.sv]
`timescale 1ns / 100ps
// Result checker for tape_machine_step: predicts each result from the accepted
// instruction transfers and compares the result transfers. Depends on tms_pkg.
module tms_checker
    import tms_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    input  wire logic [ADDR_W-1:0]   i_cfg_data,
    input  wire logic                o_cfg_ready,
    input  wire logic                i_valid,
    input  wire logic                o_stall,
    input  wire logic [OP_W-1:0]     i_opcode,
    input  wire logic [TARGET_W-1:0] i_jump_target,
    input  wire logic [BYTE_W-1:0]   i_in_byte,
    input  wire logic                o_valid,
    input  wire logic                i_stall,
    input  wire logic [ADDR_W-1:0]   o_next_address,
    input  wire logic                o_out_valid,
    input  wire logic [BYTE_W-1:0]   o_out_byte,
    input  wire logic                o_halted,
    output int                       o_mismatches,
    output int                       o_outstanding
);

    logic [ADDR_W-1:0]  prog_len;
    logic [ADDR_W-1:0]  pc;
    logic [TAPE_AW-1:0] dp;
    logic [BYTE_W-1:0]  tape [TAPE_CELLS];
    t_result            expected_results [$];

    function automatic t_result step_machine(input logic [OP_W-1:0] op,
                                             input logic [TARGET_W-1:0] target,
                                             input logic [BYTE_W-1:0] din);
        t_result           res;
        int unsigned       eff_len;
        logic [ADDR_W-1:0] nxt;
        logic [BYTE_W-1:0] cur_byte;
        res = '0;
        // lengths past the program store saturate at its depth
        eff_len = (prog_len > PROGRAM_DEPTH) ? PROGRAM_DEPTH : prog_len;
        if (pc >= eff_len) begin
            res.next_address = pc;
            res.halted       = 1'b1;
        end else begin
            cur_byte = tape[dp];
            nxt      = pc + 1'b1;
            case (op)
                OP_RIGHT: dp = dp + 1'b1;
                OP_LEFT:  dp = dp - 1'b1;
                OP_INC:   tape[dp] = cur_byte + 1'b1;
                OP_DEC:   tape[dp] = cur_byte - 1'b1;
                OP_OUT: begin
                    res.out_valid = 1'b1;
                    res.out_byte  = cur_byte;
                end
                OP_IN:    tape[dp] = din;
                OP_OPEN:  if (cur_byte == '0) nxt = ADDR_W'(target) + 1'b1;
                default:  if (cur_byte != '0) nxt = ADDR_W'(target) + 1'b1;
            endcase
            pc = nxt;
            res.next_address = pc;
            res.halted       = (pc >= eff_len);
        end
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            prog_len = '0;
            pc       = '0;
            dp       = '0;
            for (int i = 0; i < TAPE_CELLS; i++)
                tape[i] = '0;
            expected_results.delete();
        end else begin
            if (i_valid && !o_stall)
                expected_results.push_back(step_machine(i_opcode, i_jump_target, i_in_byte));
            // a new length applies from the next instruction on
            if (i_cfg_valid && o_cfg_ready)
                prog_len = i_cfg_data;
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with none expected: next_address %0d",
                           o_next_address);
                    o_mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("next_address", 32'(want.next_address), 32'(o_next_address));
                    check_field("out_valid", 32'(want.out_valid), 32'(o_out_valid));
                    check_field("out_byte", 32'(want.out_byte), 32'(o_out_byte));
                    check_field("halted", 32'(want.halted), 32'(o_halted));
                end
            end
        end
        o_outstanding = expected_results.size();
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// Testbench top for tape_machine_step: clock, reset, instruction and length
// stimulus, result stall and verdict. Depends on tms_pkg, the block and tms_checker.
module tb;
    import tms_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int IDLE_LIMIT      = 300000;   // long enough to outlast the tape clear after reset
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_PHASES   = 11;
    localparam int PHASE_ITEMS     = 140;
    localparam int NEAR_TARGET_MAX = 63;
    localparam logic [ADDR_W-1:0] LEN_ALL_ONES = '1;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_valid   = 1'b0;
    logic [ADDR_W-1:0]   i_cfg_data    = '0;
    logic                o_cfg_ready;
    logic                i_valid       = 1'b0;
    logic                o_stall;
    logic [OP_W-1:0]     i_opcode      = '0;
    logic [TARGET_W-1:0] i_jump_target = '0;
    logic [BYTE_W-1:0]   i_in_byte     = '0;
    logic                o_valid;
    logic                i_stall       = 1'b0;
    logic [ADDR_W-1:0]   o_next_address;
    logic                o_out_valid;
    logic [BYTE_W-1:0]   o_out_byte;
    logic                o_halted;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;

    tape_machine_step dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_jump_target  (i_jump_target),
        .i_in_byte      (i_in_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_next_address (o_next_address),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_halted       (o_halted)
    );

    tms_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_jump_target  (i_jump_target),
        .i_in_byte      (i_in_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_next_address (o_next_address),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_halted       (o_halted),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic write_length(input logic [ADDR_W-1:0] len);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // valid is only dropped when a gap is drawn, so back-to-back items keep it high
    task automatic send_instr(input logic [OP_W-1:0] op, input logic [TARGET_W-1:0] target,
                              input logic [BYTE_W-1:0] din);
        int gap;
        gap = tx_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_jump_target <= target;
        i_in_byte     <= din;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        @(negedge i_clk);
    endtask

    task automatic send_random_instr(input bit far_targets);
        logic [OP_W-1:0]     op;
        logic [TARGET_W-1:0] target;
        logic [BYTE_W-1:0]   din;
        op = OP_W'($urandom_range(0, 7));
        // near brackets keep the instruction address low so programs keep running
        if ((op != OP_OPEN && op != OP_CLOSE) || (far_targets && $urandom_range(0, 7) == 0))
            target = TARGET_W'($urandom);
        else
            target = TARGET_W'($urandom_range(0, NEAR_TARGET_MAX));
        din = ($urandom_range(0, 3) == 0) ? '0 : BYTE_W'($urandom);
        send_instr(op, target, din);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    initial begin
        int gap;
        forever begin
            @(negedge i_clk);
            gap = rx_idle ? $urandom_range(0, 3) : 0;
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1 || i_stall);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("tape_machine_step regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [ADDR_W-1:0] len;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero length: every instruction reports halted at address 0
        write_length('0);
        send_instr(OP_INC, '0, 8'hFF);
        send_instr(OP_OUT, '1, 8'h00);
        drain_results();

        write_length(LEN_ALL_ONES);
        send_instr(OP_OUT, '1, 8'hFF);
        send_instr(OP_INC, '0, '0);
        send_instr(OP_OUT, '0, '0);
        send_instr(OP_DEC, '0, '0);
        send_instr(OP_DEC, '0, '0);         // cell wraps below zero
        send_instr(OP_OUT, '0, '0);
        send_instr(OP_IN, '0, 8'hAA);
        send_instr(OP_CLOSE, '0, '0);       // nonzero cell: loop back
        send_instr(OP_OPEN, 20'd5, '0);     // nonzero cell: fall through
        send_instr(OP_IN, '0, 8'h00);
        send_instr(OP_CLOSE, 20'd3, '0);    // zero cell: fall through
        send_instr(OP_OPEN, 20'd9, 8'hFF);  // zero cell: skip the loop
        send_instr(OP_LEFT, '1, '0);        // pointer wraps to the top cell
        send_instr(OP_IN, '0, 8'hFF);
        send_instr(OP_INC, '0, '0);         // cell wraps above 255
        send_instr(OP_IN, '0, 8'h55);
        send_instr(OP_OUT, '0, '0);
        send_instr(OP_RIGHT, '0, '0);       // pointer wraps back to cell 0
        send_instr(OP_OUT, '0, '0);
        drain_results();

        // length drops below the current address
        write_length(ADDR_W'(1));
        send_instr(OP_RIGHT, '0, '0);
        send_instr(OP_IN, '0, 8'h12);
        drain_results();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 4)
                0:       len = ADDR_W'($urandom_range(1, 128));
                1:       len = ADDR_W'(PROGRAM_DEPTH);
                2:       len = ADDR_W'($urandom_range(129, (1 << ADDR_W) - 1));
                default: len = LEN_ALL_ONES;
            endcase
            tx_idle = (ph % 3) != 2;
            rx_idle = (ph % 3) != 1;
            write_length(len);
            repeat (PHASE_ITEMS) send_random_instr(1'b0);
            drain_results();
        end

        tx_idle = 1'b1;
        rx_idle = 1'b1;
        write_length(ADDR_W'(PROGRAM_DEPTH));
        repeat (PHASE_ITEMS) send_random_instr(1'b1);
        // bracket targeting the last address: the jump lands exactly on the depth
        send_instr(OP_IN, '0, '0);
        send_instr(OP_OPEN, '1, '0);
        send_instr(OP_INC, '0, '0);
        drain_results();

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tape_machine_step regression: pass");
        else
            $display("tape_machine_step regression: fail");
        $finish;
    end

endmodule

[files.f]
src/tms_pkg.sv
src/tms_ram.sv
src/tms_out_fifo.sv
src/tape_machine_step.sv
verif/tms_checker.sv
verif/tb.sv
